// ===== rtl/bps_pkg.sv =====
// Shared types, constants and floating-point helpers for the bone palette
// skinning block. No dependencies.
`default_nettype none
package bps_pkg;

	localparam int WORDS_PER_BONE = 12;
	localparam int ROWS = 3;
	localparam int COLS = 4;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_SKIN  = 1'b1;

	localparam logic [31:0] QNAN_DEFAULT = 32'hFFC0_0000;
	localparam logic [31:0] QUIET_BIT    = 32'h0040_0000;

	typedef logic [31:0] fp32_t;

	// Unrounded operation result; a magnitude with its msb at bit 47 has biased exponent e.
	typedef struct packed {
		logic                spec;
		fp32_t               spec_val;
		logic                sign;
		logic signed [10:0]  e;
		logic [48:0]         mag;
	} fpre_t;

	typedef struct packed {
		logic                spec;
		fp32_t               spec_val;
		logic                sign;
		logic                zero;
		logic signed [10:0]  e;
		logic [47:0]         sig;
	} fnorm_t;

	typedef struct packed {
		logic bad;
		logic eob;
	} flag_t;

	function automatic logic [5:0] fp_lzc48(input logic [47:0] v);
		logic [5:0] n;
		n = 6'd48;
		for (int i = 0; i < 48; i++) begin
			if (v[i]) n = 6'(47 - i);
		end
		return n;
	endfunction

	// Round to nearest even and pack; results below the normal range become denormals.
	function automatic fp32_t fp_round(input logic sign, input logic signed [10:0] e,
			input logic [47:0] sig);
		logic [10:0] d;
		logic [5:0]  sh;
		logic [47:0] shd;
		logic [47:0] lost;
		logic [23:0] m;
		logic        g;
		logic        st;
		logic        up;
		logic [7:0]  ef;
		fp32_t       r;
		d = 11'(11'sd1 - e);
		if (e > 11'sd0) sh = 6'd0;
		else if (d > 11'd48) sh = 6'd48;
		else sh = d[5:0];
		shd  = sig >> sh;
		lost = sig & ~({48{1'b1}} << sh);
		m    = shd[47:24];
		g    = shd[23];
		st   = (|shd[22:0]) | (|lost);
		up   = g & (st | m[0]);
		ef   = (e > 11'sd0) ? e[7:0] : 8'd0;
		if (e > 11'sd254) r = {sign, 8'hFF, 23'd0};
		else r = {sign, ef, m[22:0]} + {31'd0, up};
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/bps_if.sv =====
// Request channel interfaces of the skinning block: vertex and palette requests in,
// transformed positions out. No dependencies.
`default_nettype none
interface bps_in_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [7:0]  bone;
	logic [3:0]  word_sel;
	logic [31:0] word_value;
	logic [31:0] pos_x;
	logic [31:0] pos_y;
	logic [31:0] pos_z;
	logic        batch_end;
	modport source(output valid, op, bone, word_sel, word_value, pos_x, pos_y, pos_z,
		batch_end, input ready);
	modport sink(input valid, op, bone, word_sel, word_value, pos_x, pos_y, pos_z,
		batch_end, output ready);
endinterface

interface bps_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_x;
	logic [31:0] out_y;
	logic [31:0] out_z;
	logic        bad_bone;
	logic        end_of_batch;
	modport source(output valid, out_x, out_y, out_z, bad_bone, end_of_batch, input ready);
	modport sink(input valid, out_x, out_y, out_z, bad_bone, end_of_batch, output ready);
endinterface
`default_nettype wire

// ===== rtl/bone_palette_vertex_skinning.sv =====
// Rigid matrix palette skinning: 12 palette RAMs (one per matrix word) feeding three rows
// of multiply and three chained adds. One request per cycle, limited by the single palette
// read per vertex. The whole pipeline stalls while an unaccepted result waits. Reset
// clears the valid pipeline only; palette contents are undefined until written. Depends on
// bps_pkg, bps_if, bps_ram, bps_fop.
`default_nettype none
module bone_palette_vertex_skinning #(
	parameter int NUM_BONES = 128
) (
	input wire logic    clk,
	input wire logic    arst_n,
	bps_in_if.sink      vertex,
	bps_out_if.source   result
);
	import bps_pkg::*;

	localparam int AW    = (NUM_BONES > 1) ? $clog2(NUM_BONES) : 1;
	localparam int DEPTH = 13;

	logic   en;
	logic   acc;
	logic   bone_ok;
	logic   vld_q [DEPTH];
	flag_t  fl_q  [DEPTH];
	fp32_t  m_s1  [WORDS_PER_BONE];
	fp32_t  pos_s1 [ROWS];
	fp32_t  res_y [ROWS];

	assign en           = !vld_q[DEPTH-1] || result.ready;
	assign vertex.ready = en;
	assign acc          = vertex.valid && en;
	assign bone_ok      = {1'b0, vertex.bone} < 9'(NUM_BONES);

	// A write and a later vertex read never meet at one edge, so no forwarding is needed.
	generate
		for (genvar k = 0; k < WORDS_PER_BONE; k++) begin : g_ram
			bps_ram #(.WIDTH(32), .DEPTH(NUM_BONES)) u_ram (
				.clk  (clk),
				.we   (acc && (vertex.op == OP_WRITE) && bone_ok &&
					(vertex.word_sel == 4'(k))),
				.waddr(vertex.bone[AW-1:0]),
				.wdata(vertex.word_value),
				.re   (en),
				.raddr(vertex.bone[AW-1:0]),
				.rdata(m_s1[k])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) vld_q[i] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= acc && (vertex.op == OP_SKIN);
			for (int i = 1; i < DEPTH; i++) vld_q[i] <= vld_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s1[0] <= vertex.pos_x;
			pos_s1[1] <= vertex.pos_y;
			pos_s1[2] <= vertex.pos_z;
			fl_q[0]   <= '{bad: !bone_ok, eob: vertex.batch_end};
			for (int i = 1; i < DEPTH; i++) fl_q[i] <= fl_q[i-1];
		end
	end

	generate
		for (genvar r = 0; r < ROWS; r++) begin : g_row
			fp32_t prod [3];
			fp32_t sum_xy;
			fp32_t sum_xyz;
			fp32_t pz_q [3];
			fp32_t m3_q [9];

			for (genvar c = 0; c < 3; c++) begin : g_mul
				bps_fop #(.IS_ADD(1'b0)) u_mul (
					.clk(clk), .en(en), .a(pos_s1[c]), .b(m_s1[r*COLS+c]), .y(prod[c])
				);
			end

			always_ff @(posedge clk) begin
				if (en) begin
					pz_q[0] <= prod[2];
					pz_q[1] <= pz_q[0];
					pz_q[2] <= pz_q[1];
					m3_q[0] <= m_s1[r*COLS+3];
					for (int i = 1; i < 9; i++) m3_q[i] <= m3_q[i-1];
				end
			end

			bps_fop #(.IS_ADD(1'b1)) u_add_xy (
				.clk(clk), .en(en), .a(prod[0]), .b(prod[1]), .y(sum_xy)
			);
			bps_fop #(.IS_ADD(1'b1)) u_add_z (
				.clk(clk), .en(en), .a(sum_xy), .b(pz_q[2]), .y(sum_xyz)
			);
			bps_fop #(.IS_ADD(1'b1)) u_add_t (
				.clk(clk), .en(en), .a(sum_xyz), .b(m3_q[8]), .y(res_y[r])
			);
		end
	endgenerate

	assign result.valid        = vld_q[DEPTH-1];
	assign result.bad_bone     = fl_q[DEPTH-1].bad;
	assign result.end_of_batch = fl_q[DEPTH-1].eob;
	assign result.out_x        = fl_q[DEPTH-1].bad ? 32'd0 : res_y[0];
	assign result.out_y        = fl_q[DEPTH-1].bad ? 32'd0 : res_y[1];
	assign result.out_z        = fl_q[DEPTH-1].bad ? 32'd0 : res_y[2];
endmodule
`default_nettype wire

// ===== rtl/bps_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bps_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/bps_fop.sv =====
// Three-stage IEEE single multiplier or adder: operate, normalize, round.
// Depends on bps_pkg.
`default_nettype none
module bps_fop #(
	parameter bit IS_ADD = 1'b0
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire bps_pkg::fp32_t a,
	input  wire bps_pkg::fp32_t b,
	output bps_pkg::fp32_t      y
);
	import bps_pkg::*;

	fpre_t  pre;
	fpre_t  pre_s1;
	fnorm_t nrm;
	fnorm_t nrm_s2;
	fp32_t  y_s3;

	logic a_nan, b_nan, a_inf, b_inf;

	assign a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
	assign b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
	assign a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
	assign b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);

	generate
		if (IS_ADD) begin : g_add
			always_comb begin : add_pre
				logic        swap;
				fp32_t       bg;
				fp32_t       sm;
				logic [7:0]  eg;
				logic [7:0]  es;
				logic [7:0]  d;
				logic [48:0] ag;
				logic [48:0] as0;
				logic [48:0] ash;
				logic [48:0] lost;
				logic        sub;
				logic [48:0] mag;
				swap = b[30:0] > a[30:0];
				bg   = swap ? b : a;
				sm   = swap ? a : b;
				eg   = (bg[30:23] == 8'd0) ? 8'd1 : bg[30:23];
				es   = (sm[30:23] == 8'd0) ? 8'd1 : sm[30:23];
				d    = eg - es;
				ag   = {1'b0, (bg[30:23] != 8'd0), bg[22:0], 24'd0};
				as0  = {1'b0, (sm[30:23] != 8'd0), sm[22:0], 24'd0};
				ash  = as0 >> d;
				lost = as0 & ~({49{1'b1}} << d);
				ash[0] = ash[0] | (|lost);
				sub  = bg[31] ^ sm[31];
				mag  = sub ? (ag - ash) : (ag + ash);
				pre.mag  = mag;
				pre.e    = $signed({3'b000, eg});
				// Exact cancellation gives +0; only two negative zeros keep the sign.
				pre.sign = (mag == 49'd0) ? (bg[31] & ~sub) : bg[31];
				pre.spec = a_nan | b_nan | a_inf | b_inf;
				if (a_nan) pre.spec_val = a | QUIET_BIT;
				else if (b_nan) pre.spec_val = b | QUIET_BIT;
				else if (a_inf && b_inf && (a[31] != b[31])) pre.spec_val = QNAN_DEFAULT;
				else if (a_inf) pre.spec_val = a;
				else pre.spec_val = b;
			end
		end else begin : g_mul
			logic a_zero, b_zero;

			assign a_zero = (a[30:0] == 31'd0);
			assign b_zero = (b[30:0] == 31'd0);

			always_comb begin : mul_pre
				logic [7:0]  ea;
				logic [7:0]  eb;
				logic [23:0] ma;
				logic [23:0] mb;
				logic [47:0] prod;
				ea   = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
				eb   = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
				ma   = {(a[30:23] != 8'd0), a[22:0]};
				mb   = {(b[30:23] != 8'd0), b[22:0]};
				prod = ma * mb;
				pre.mag  = {1'b0, prod};
				pre.e    = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd126;
				pre.sign = a[31] ^ b[31];
				pre.spec = a_nan | b_nan | a_inf | b_inf;
				if (a_nan) pre.spec_val = a | QUIET_BIT;
				else if (b_nan) pre.spec_val = b | QUIET_BIT;
				else if ((a_inf && b_zero) || (a_zero && b_inf)) pre.spec_val = QNAN_DEFAULT;
				else pre.spec_val = {a[31] ^ b[31], 8'hFF, 23'd0};
			end
		end
	endgenerate

	always_comb begin
		logic [5:0] lz;
		lz = fp_lzc48(pre_s1.mag[47:0]);
		nrm.spec     = pre_s1.spec;
		nrm.spec_val = pre_s1.spec_val;
		nrm.sign     = pre_s1.sign;
		nrm.zero     = (pre_s1.mag == 49'd0);
		if (pre_s1.mag[48]) begin
			nrm.sig = {pre_s1.mag[48:2], pre_s1.mag[1] | pre_s1.mag[0]};
			nrm.e   = pre_s1.e + 11'sd1;
		end else begin
			nrm.sig = pre_s1.mag[47:0] << lz;
			nrm.e   = pre_s1.e - $signed({5'b00000, lz});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pre_s1 <= pre;
			nrm_s2 <= nrm;
			if (nrm_s2.spec) y_s3 <= nrm_s2.spec_val;
			else if (nrm_s2.zero) y_s3 <= {nrm_s2.sign, 31'd0};
			else y_s3 <= fp_round(nrm_s2.sign, nrm_s2.e, nrm_s2.sig);
		end
	end

	assign y = y_s3;
endmodule
`default_nettype wire

// ===== rtl/bps_chk.sv =====
// Port-level checks on the result channel of the skinning block, bound to the top level.
// Depends on bone_palette_vertex_skinning.
`default_nettype none
module bps_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        valid,
	input wire logic        ready,
	input wire logic [31:0] out_x,
	input wire logic [31:0] out_y,
	input wire logic [31:0] out_z,
	input wire logic        bad_bone,
	input wire logic        end_of_batch
);
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid)
		else $error("result request dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> $stable(out_x) && $stable(out_y) && $stable(out_z) &&
			$stable(bad_bone) && $stable(end_of_batch))
		else $error("result payload changed while stalled");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid && bad_bone |-> out_x == 32'd0 && out_y == 32'd0 && out_z == 32'd0)
		else $error("bad bone result carries nonzero position");

	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !valid)
		else $error("result valid right after reset");
endmodule

bind bone_palette_vertex_skinning bps_chk u_bps_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.valid       (result.valid),
	.ready       (result.ready),
	.out_x       (result.out_x),
	.out_y       (result.out_y),
	.out_z       (result.out_z),
	.bad_bone    (result.bad_bone),
	.end_of_batch(result.end_of_batch)
);
`default_nettype wire

// ===== dv/bone_palette_vertex_skinning_tb.sv =====
// Testbench for bone_palette_vertex_skinning: directed and random palette writes and vertex
// requests checked against a bit-exact single-precision predictor kept in a scoreboard class.
// Depends on bps_pkg, bps_if and the block itself.
`timescale 1ns / 100ps
module bone_palette_vertex_skinning_tb;
	import bps_pkg::*;

	localparam int NUM_BONES = 128;
	localparam int RANDOM_ITEMS = 700;

	typedef struct {
		logic        op;
		logic [7:0]  bone;
		logic [3:0]  word_sel;
		fp32_t       word_value;
		fp32_t       pos_x;
		fp32_t       pos_y;
		fp32_t       pos_z;
		logic        batch_end;
	} request_t;

	typedef struct {
		fp32_t out_x;
		fp32_t out_y;
		fp32_t out_z;
		logic  bad_bone;
		logic  end_of_batch;
	} position_t;

	localparam fp32_t DEFAULT_NAN = 32'hFFC0_0000;

	function automatic bit is_nan(fp32_t f);
		return f[30:23] == 8'hFF && f[22:0] != 0;
	endfunction

	function automatic bit is_inf(fp32_t f);
		return f[30:23] == 8'hFF && f[22:0] == 0;
	endfunction

	function automatic bit is_zero(fp32_t f);
		return f[30:0] == 0;
	endfunction

	// Value is sig * 2^ex.
	function automatic void split_fp(input fp32_t f, output int ex, output bit [63:0] sig);
		if (f[30:23] == 0) begin
			sig = {41'd0, f[22:0]};
			ex = -149;
		end else begin
			sig = {40'd0, 1'b1, f[22:0]};
			ex = int'(f[30:23]) - 150;
		end
	endfunction

	// Rounds sign * sig * 2^ex (sig nonzero) to nearest even, keeping denormals.
	function automatic fp32_t round_pack(bit s, int ex, bit [63:0] sig);
		int p, be, sh;
		bit [127:0] w;
		bit [63:0] q;
		bit g, st;
		bit [30:0] mag;
		p = 0;
		for (int i = 0; i < 64; i++) begin
			if (sig[i]) p = i;
		end
		be = p + ex + 127;
		if (be > 254) return {s, 8'hFF, 23'd0};
		sh = p - 23;
		if (be < 1) sh += 1 - be;
		if (sh > 0) begin
			if (sh > 100) sh = 100;
			w = {sig, 64'd0} >> sh;
			q = w[127:64];
			g = w[63];
			st = |w[62:0];
		end else begin
			q = sig << (-sh);
			g = 0;
			st = 0;
		end
		mag = ((be >= 1) ? 31'(be) << 23 : 31'd0) + {8'd0, q[22:0]} + 31'(g & (st | q[0]));
		return {s, mag};
	endfunction

	function automatic fp32_t fp_mul(fp32_t a, fp32_t b);
		int ea, eb;
		bit [63:0] ma, mb;
		bit s;
		s = a[31] ^ b[31];
		if (is_nan(a)) return a | QUIET_BIT;
		if (is_nan(b)) return b | QUIET_BIT;
		if ((is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b))) return DEFAULT_NAN;
		if (is_inf(a) || is_inf(b)) return {s, 8'hFF, 23'd0};
		if (is_zero(a) || is_zero(b)) return {s, 31'd0};
		split_fp(a, ea, ma);
		split_fp(b, eb, mb);
		return round_pack(s, ea + eb, ma * mb);
	endfunction

	function automatic fp32_t fp_add(fp32_t a, fp32_t b);
		int ea, eb, d;
		bit [63:0] ma, mb, big, tiny, sum;
		bit sbig, stiny, s;
		if (is_nan(a)) return a | QUIET_BIT;
		if (is_nan(b)) return b | QUIET_BIT;
		if (is_inf(a) && is_inf(b) && a[31] != b[31]) return DEFAULT_NAN;
		if (is_inf(a)) return a;
		if (is_inf(b)) return b;
		if (is_zero(a) && is_zero(b)) return {a[31] & b[31], 31'd0};
		if (is_zero(a)) return b;
		if (is_zero(b)) return a;
		split_fp(a, ea, ma);
		split_fp(b, eb, mb);
		if (ea < eb) begin
			{ea, eb} = {eb, ea};
			{ma, mb} = {mb, ma};
			sbig = b[31];
			stiny = a[31];
		end else begin
			sbig = a[31];
			stiny = b[31];
		end
		// The larger operand sits 39 bits up; anything shifted out of the smaller one
		// is folded into bit zero, far below the rounding point.
		big = ma << 39;
		d = ea - eb;
		if (d <= 39) tiny = mb << (39 - d);
		else if (d - 39 >= 64) tiny = 64'd1;
		else tiny = (mb >> (d - 39)) | 64'(|(mb & ((64'd1 << (d - 39)) - 1)));
		if (sbig == stiny) begin
			sum = big + tiny;
			s = sbig;
		end else if (big > tiny) begin
			sum = big - tiny;
			s = sbig;
		end else if (tiny > big) begin
			sum = tiny - big;
			s = stiny;
		end else begin
			return 32'd0;
		end
		return round_pack(s, ea - 39, sum);
	endfunction

	class skin_scoreboard;
		fp32_t palette [NUM_BONES * WORDS_PER_BONE];
		position_t expected_q [$];
		int errors;

		function fp32_t transform_row(int base, fp32_t x, fp32_t y, fp32_t z);
			fp32_t acc;
			acc = fp_add(fp_mul(x, palette[base]), fp_mul(y, palette[base + 1]));
			acc = fp_add(acc, fp_mul(z, palette[base + 2]));
			return fp_add(acc, palette[base + 3]);
		endfunction

		function void note_request(request_t r);
			position_t p;
			int base;
			if (r.op == OP_WRITE) begin
				if (r.bone < NUM_BONES && r.word_sel < WORDS_PER_BONE)
					palette[r.bone * WORDS_PER_BONE + r.word_sel] = r.word_value;
				return;
			end
			p.end_of_batch = r.batch_end;
			if (r.bone >= NUM_BONES) begin
				p.out_x = 32'd0;
				p.out_y = 32'd0;
				p.out_z = 32'd0;
				p.bad_bone = 1'b1;
			end else begin
				base = r.bone * WORDS_PER_BONE;
				p.out_x = transform_row(base, r.pos_x, r.pos_y, r.pos_z);
				p.out_y = transform_row(base + 4, r.pos_x, r.pos_y, r.pos_z);
				p.out_z = transform_row(base + 8, r.pos_x, r.pos_y, r.pos_z);
				p.bad_bone = 1'b0;
			end
			expected_q.push_back(p);
		endfunction

		function void check_result(position_t got);
			position_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result x=%h y=%h z=%h", $time,
					got.out_x, got.out_y, got.out_z);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.out_x !== want.out_x) begin
				$display("%0t: out_x expected %h actual %h", $time, want.out_x, got.out_x);
				errors++;
			end
			if (got.out_y !== want.out_y) begin
				$display("%0t: out_y expected %h actual %h", $time, want.out_y, got.out_y);
				errors++;
			end
			if (got.out_z !== want.out_z) begin
				$display("%0t: out_z expected %h actual %h", $time, want.out_z, got.out_z);
				errors++;
			end
			if (got.bad_bone !== want.bad_bone) begin
				$display("%0t: bad_bone expected %b actual %b", $time,
					want.bad_bone, got.bad_bone);
				errors++;
			end
			if (got.end_of_batch !== want.end_of_batch) begin
				$display("%0t: end_of_batch expected %b actual %b", $time,
					want.end_of_batch, got.end_of_batch);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bps_in_if  vertex_ch();
	bps_out_if result_ch();
	skin_scoreboard sb;
	bit written [NUM_BONES][WORDS_PER_BONE];
	int ready_bones [$];

	bone_palette_vertex_skinning #(.NUM_BONES(NUM_BONES)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.vertex(vertex_ch),
		.result(result_ch)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("FAIL bone_palette_vertex_skinning");
		$finish;
	end

	function automatic int gap_cycles();
		int r;
		r = $urandom_range(99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic fp32_t random_float();
		int r;
		r = $urandom_range(99);
		if (r < 60) return {1'($urandom), 8'($urandom_range(115, 135)), 23'($urandom)};
		if (r < 75) return $urandom;
		if (r < 85) return {1'($urandom), 8'd0, 23'($urandom)};
		case ($urandom_range(5))
			0: return 32'h0000_0000;
			1: return 32'h8000_0000;
			2: return 32'h7F80_0000;
			3: return 32'hFF80_0000;
			4: return 32'h7F7F_FFFF;
			default: return 32'h3F80_0000;
		endcase
	endfunction

	// Samples at the falling edge, where no signal is changing.
	always @(negedge clk) begin
		request_t r;
		position_t p;
		if (arst_n && vertex_ch.valid && vertex_ch.ready) begin
			r.op = vertex_ch.op;
			r.bone = vertex_ch.bone;
			r.word_sel = vertex_ch.word_sel;
			r.word_value = vertex_ch.word_value;
			r.pos_x = vertex_ch.pos_x;
			r.pos_y = vertex_ch.pos_y;
			r.pos_z = vertex_ch.pos_z;
			r.batch_end = vertex_ch.batch_end;
			sb.note_request(r);
		end
		if (arst_n && result_ch.valid && result_ch.ready) begin
			p.out_x = result_ch.out_x;
			p.out_y = result_ch.out_y;
			p.out_z = result_ch.out_z;
			p.bad_bone = result_ch.bad_bone;
			p.end_of_batch = result_ch.end_of_batch;
			sb.check_result(p);
		end
	end

	initial begin
		int n;
		result_ch.ready = 0;
		@(posedge arst_n);
		forever begin
			n = ($urandom_range(9) == 0) ? 0 : gap_cycles();
			if (n > 0) begin
				@(posedge clk);
				result_ch.ready <= 0;
				repeat (n - 1) @(posedge clk);
			end
			@(posedge clk);
			result_ch.ready <= 1;
			repeat ($urandom_range(9) == 0 ? 60 : $urandom_range(0, 6)) @(posedge clk);
		end
	end

	task automatic send_request(request_t r);
		int n;
		bit taken;
		n = gap_cycles();
		if (n > 0) begin
			vertex_ch.valid <= 0;
			repeat (n) @(posedge clk);
		end
		vertex_ch.valid <= 1;
		vertex_ch.op <= r.op;
		vertex_ch.bone <= r.bone;
		vertex_ch.word_sel <= r.word_sel;
		vertex_ch.word_value <= r.word_value;
		vertex_ch.pos_x <= r.pos_x;
		vertex_ch.pos_y <= r.pos_y;
		vertex_ch.pos_z <= r.pos_z;
		vertex_ch.batch_end <= r.batch_end;
		do begin
			@(negedge clk);
			taken = vertex_ch.ready;
			@(posedge clk);
		end while (!taken);
		if (r.op == OP_WRITE && r.bone < NUM_BONES && r.word_sel < WORDS_PER_BONE &&
				!written[r.bone][r.word_sel]) begin
			written[r.bone][r.word_sel] = 1;
			n = 0;
			for (int i = 0; i < WORDS_PER_BONE; i++) n += written[r.bone][i];
			if (n == WORDS_PER_BONE) ready_bones.push_back(r.bone);
		end
	endtask

	task automatic write_word(int bone, int sel, fp32_t value);
		request_t r;
		r.op = OP_WRITE;
		r.bone = 8'(bone);
		r.word_sel = 4'(sel);
		r.word_value = value;
		r.pos_x = $urandom;
		r.pos_y = $urandom;
		r.pos_z = $urandom;
		r.batch_end = 1'($urandom);
		send_request(r);
	endtask

	task automatic skin_vertex(int bone, fp32_t x, fp32_t y, fp32_t z, bit last);
		request_t r;
		r.op = OP_SKIN;
		r.bone = 8'(bone);
		r.word_sel = 4'($urandom);
		r.word_value = $urandom;
		r.pos_x = x;
		r.pos_y = y;
		r.pos_z = z;
		r.batch_end = last;
		send_request(r);
	endtask

	initial begin
		int waited;
		fp32_t m0 [WORDS_PER_BONE] = '{32'h3F80_0000, 32'h0000_0001, 32'hBF80_0000,
			32'h4120_0000, 32'h8000_0000, 32'h3F80_0000, 32'h7F7F_FFFF, 32'h0080_0000,
			32'h3F00_0000, 32'h807F_FFFF, 32'h4000_0000, 32'hC2C8_0000};
		sb = new();
		arst_n = 0;
		vertex_ch.valid = 0;
		vertex_ch.op = OP_WRITE;
		vertex_ch.bone = 0;
		vertex_ch.word_sel = 0;
		vertex_ch.word_value = 0;
		vertex_ch.pos_x = 0;
		vertex_ch.pos_y = 0;
		vertex_ch.pos_z = 0;
		vertex_ch.batch_end = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed part: full matrix for bone 0, out-of-range writes, extreme positions,
		// vertices on two bones outside the palette.
		for (int i = 0; i < WORDS_PER_BONE; i++) write_word(0, i, m0[i]);
		write_word(255, 15, 32'hFFFF_FFFF);
		write_word(0, 12, 32'h7FC0_0000);
		write_word(200, 3, 32'h1234_5678);
		skin_vertex(0, 32'h3F80_0000, 32'h4000_0000, 32'h4040_0000, 0);
		skin_vertex(0, 32'hFFFF_FFFF, 32'h0000_0000, 32'h7F80_0000, 1);
		skin_vertex(0, 32'h0000_0001, 32'h807F_FFFF, 32'hFF80_0000, 0);
		skin_vertex(0, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h8000_0000, 1);
		skin_vertex(0, 32'h7F80_0001, 32'h3F80_0000, 32'h3F80_0000, 0);
		skin_vertex(255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
		skin_vertex(128, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 0);

		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			int r;
			r = $urandom_range(99);
			if (r < 30) begin
				// Palette writes mostly land on a few bones so that matrices complete.
				if ($urandom_range(9) < 7)
					write_word($urandom_range(0, 5) == 0 ? NUM_BONES - 1 : $urandom_range(0, 7),
						$urandom_range(0, WORDS_PER_BONE - 1), random_float());
				else
					write_word($urandom_range(0, 255), $urandom_range(0, 15), $urandom);
			end else if (r < 37) begin
				skin_vertex($urandom_range(NUM_BONES, 255), $urandom, $urandom, $urandom,
					$urandom);
			end else begin
				skin_vertex(ready_bones[$urandom_range(0, ready_bones.size() - 1)],
					random_float(), random_float(), random_float(), $urandom_range(7) == 0);
			end
		end
		vertex_ch.valid <= 0;

		waited = 0;
		while (sb.expected_q.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("PASS bone_palette_vertex_skinning");
		end else begin
			$display("FAIL bone_palette_vertex_skinning");
		end
		$finish;
	end

endmodule
